### hw/rtl/magma_block_cipher_assert.svh
// Assertion macros used by the checker.
`ifndef MAGMA_BLOCK_CIPHER_ASSERT_SVH
`define MAGMA_BLOCK_CIPHER_ASSERT_SVH

// Implication, checked only out of reset.
`define MBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("magma assertion failed");

// Next-cycle implication, checked only out of reset.
`define MBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("magma assertion failed");

// Implication, checked during reset as well.
`define MBC_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("magma assertion failed");

`endif

### hw/rtl/mbc_pkg.sv
`default_nettype none

package mbc_pkg;

    localparam int MBC_ROUNDS   = 32;
    localparam int MBC_KEY_REGS = 4;
    localparam int MBC_KEY_WORDS = 2 * MBC_KEY_REGS;
    localparam int MBC_BLK_W    = 64;
    localparam int MBC_HALF_W   = 32;
    localparam int MBC_CFG_W    = 64;
    localparam int MBC_IDX_W    = 2;
    localparam int MBC_ROT      = 11;

    localparam logic MBC_OP_ENC = 1'b0;
    localparam logic MBC_OP_DEC = 1'b1;

    localparam logic [MBC_IDX_W-1:0] MBC_REG_KEY_255_192 = 2'd0;
    localparam logic [MBC_IDX_W-1:0] MBC_REG_KEY_191_128 = 2'd1;
    localparam logic [MBC_IDX_W-1:0] MBC_REG_KEY_127_64  = 2'd2;
    localparam logic [MBC_IDX_W-1:0] MBC_REG_KEY_63_0    = 2'd3;

    typedef logic [MBC_HALF_W-1:0] t_mbc_word;
    typedef logic [MBC_BLK_W-1:0]  t_mbc_block;
    typedef logic [MBC_KEY_WORDS-1:0][MBC_HALF_W-1:0] t_mbc_keys;

    typedef struct packed {
        logic valid;
        logic dec;
    } t_mbc_ctl;

    typedef logic [3:0] t_mbc_nib;

    localparam t_mbc_nib MBC_SBOX [8][16] = '{
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
    };

    // Round function: add mod 2^32, S-box layer, rotate left.
    function automatic t_mbc_word mbc_g(input t_mbc_word a, input t_mbc_word k);
        t_mbc_word s;
        t_mbc_word r;
        s = a + k;
        for (int n = 0; n < 8; n++) begin
            r[4*n +: 4] = MBC_SBOX[n][s[4*n +: 4]];
        end
        return {r[MBC_HALF_W-MBC_ROT-1:0], r[MBC_HALF_W-1:MBC_HALF_W-MBC_ROT]};
    endfunction

    // Key word index (K1..K8 as 0..7) used in round r.
    function automatic logic [2:0] mbc_key_idx(input int r, input logic dec);
        int rr;
        logic [2:0] lo;
        rr = (dec == MBC_OP_DEC) ? (MBC_ROUNDS - 1 - r) : r;
        lo = rr[2:0];
        return (rr < MBC_ROUNDS - 8) ? lo : (3'd7 - lo);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/magma_block_cipher.sv
// Channel   Handshake                  Payload
// cfg       i_cfg_we                   i_cfg_idx, i_cfg_data
// in        i_in_valid / o_in_ready    i_opcode, i_block_in
// out       o_out_valid / i_out_ready  o_block_out
//
// 32 round stages, one round per stage; one block per cycle while the output is not stalled.
// Each stage loads when it is empty or the next one loads, so bubbles collapse
// and a stalled output does not block input while empty stages remain.
// Synchronous active-low reset clears the key registers and all stage valids.
// Keys are read directly by the stages; write them only while the pipe is empty.
`default_nettype none

module magma_block_cipher (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mbc_pkg::MBC_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mbc_pkg::MBC_CFG_W-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_ready,
    input  wire logic                          i_opcode,
    input  wire logic [mbc_pkg::MBC_BLK_W-1:0] i_block_in,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    output      logic [mbc_pkg::MBC_BLK_W-1:0] o_block_out
);
    import mbc_pkg::*;

    t_mbc_keys              s_words;
    t_mbc_ctl               s_ctl [MBC_ROUNDS+1];
    t_mbc_block             s_blk [MBC_ROUNDS+1];
    t_mbc_word              s_key [MBC_ROUNDS];
    logic [MBC_ROUNDS-1:0]  s_en;

    mbc_key_regs u_keys (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_words (s_words)
    );

    assign s_ctl[0] = '{valid: i_in_valid, dec: (i_opcode == MBC_OP_DEC)};
    assign s_blk[0] = i_block_in;

    for (genvar g = 0; g < MBC_ROUNDS; g++) begin : g_round
        localparam logic [2:0] EncIdx = mbc_key_idx(g, MBC_OP_ENC);
        localparam logic [2:0] DecIdx = mbc_key_idx(g, MBC_OP_DEC);

        assign s_key[g] = s_ctl[g].dec ? s_words[DecIdx] : s_words[EncIdx];

        if (g == MBC_ROUNDS - 1) begin : g_tail
            assign s_en[g] = !s_ctl[g+1].valid || i_out_ready;
        end else begin : g_body
            assign s_en[g] = !s_ctl[g+1].valid || s_en[g+1];
        end

        mbc_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en[g]),
            .i_ctl   (s_ctl[g]),
            .i_block (s_blk[g]),
            .i_key   (s_key[g]),
            .o_ctl   (s_ctl[g+1]),
            .o_block (s_blk[g+1])
        );
    end

    assign o_in_ready  = s_en[0];
    assign o_out_valid = s_ctl[MBC_ROUNDS].valid;
    // final round keeps halves in place
    assign o_block_out = {s_blk[MBC_ROUNDS][MBC_HALF_W-1:0],
                          s_blk[MBC_ROUNDS][MBC_BLK_W-1:MBC_HALF_W]};

endmodule

`default_nettype wire

### hw/rtl/mbc_key_regs.sv
`default_nettype none

module mbc_key_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_we,
    input  wire logic [mbc_pkg::MBC_IDX_W-1:0] i_idx,
    input  wire logic [mbc_pkg::MBC_CFG_W-1:0] i_data,
    output mbc_pkg::t_mbc_keys                 o_words
);
    import mbc_pkg::*;

    logic [MBC_CFG_W-1:0] r_key [MBC_KEY_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MBC_KEY_REGS; j++) begin
                r_key[j] <= '0;
            end
        end else if (i_we) begin
            unique case (i_idx)
                MBC_REG_KEY_255_192: r_key[0] <= i_data;
                MBC_REG_KEY_191_128: r_key[1] <= i_data;
                MBC_REG_KEY_127_64:  r_key[2] <= i_data;
                MBC_REG_KEY_63_0:    r_key[3] <= i_data;
                default:             r_key[0] <= r_key[0];
            endcase
        end
    end

    always_comb begin
        for (int j = 0; j < MBC_KEY_REGS; j++) begin
            o_words[2*j]     = r_key[j][MBC_CFG_W-1:MBC_HALF_W];
            o_words[2*j + 1] = r_key[j][MBC_HALF_W-1:0];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mbc_round.sv
`default_nettype none

// One Feistel round with its pipeline register. Halves always swap; the
// top level undoes the swap after the final round.
module mbc_round (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire mbc_pkg::t_mbc_ctl   i_ctl,
    input  wire mbc_pkg::t_mbc_block i_block,
    input  wire mbc_pkg::t_mbc_word  i_key,
    output mbc_pkg::t_mbc_ctl   o_ctl,
    output mbc_pkg::t_mbc_block o_block
);
    import mbc_pkg::*;

    t_mbc_ctl   r_ctl;
    t_mbc_block r_block;
    t_mbc_block n_block;

    always_comb begin
        n_block = {i_block[MBC_HALF_W-1:0],
                   i_block[MBC_BLK_W-1:MBC_HALF_W] ^ mbc_g(i_block[MBC_HALF_W-1:0], i_key)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_block <= n_block;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_block = r_block;

endmodule

`default_nettype wire

### hw/rtl/mbc_checker.sv
`default_nettype none
`include "magma_block_cipher_assert.svh"

module mbc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_cfg_we,
    input wire logic [mbc_pkg::MBC_IDX_W-1:0] i_cfg_idx,
    input wire logic [mbc_pkg::MBC_CFG_W-1:0] i_cfg_data,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          i_opcode,
    input wire logic [mbc_pkg::MBC_BLK_W-1:0] i_block_in,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [mbc_pkg::MBC_BLK_W-1:0] o_block_out
);
    import mbc_pkg::*;

    logic s_cfg_seen;
    logic s_in_seen;

    assign s_cfg_seen = i_cfg_we && (i_cfg_idx == MBC_REG_KEY_255_192 || i_cfg_data == '0);
    assign s_in_seen  = i_in_valid && (i_opcode == MBC_OP_DEC || i_block_in == '0);

    // no beat out right after reset
    `MBC_ASSERT_RST(a_out_idle_after_rst, i_clk, i_rst_n && $past(!i_rst_n), !o_out_valid)
    // a taken output frees the whole pipe
    `MBC_ASSERT_IMP(a_ready_when_drained, i_clk, i_rst_n, i_out_ready, o_in_ready)
    // an empty output stage never backpressures
    `MBC_ASSERT_IMP(a_ready_when_out_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    // stalled result holds
    `MBC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
                    o_out_valid && $stable(o_block_out))
    // input stalls only behind a stalled result
    `MBC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, (s_in_seen || s_cfg_seen) && !o_in_ready,
                    o_out_valid && !i_out_ready)

endmodule

bind magma_block_cipher mbc_checker u_mbc_checker (.*);

`default_nettype wire
